[sv/bfd_pkg.sv]
// Shared types and constants of the best-fit decreasing strip packer.
package bfd_pkg;

   localparam int ROW_COUNT_W = 11;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sort_init;
      logic sort_readi;
      logic sort_latch_v;
      logic sort_readj;
      logic sort_shift;
      logic sort_place;
      logic pack_init;
      logic pack_readi;
      logic pack_latch_w;
      logic scan_step;
      logic pack_update;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic i_done;
      logic j_zero;
      logic cmp_less;
      logic scan_done;
   } status_type;

endpackage

[sv/bfd_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module bfd_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/bfd_ctrl.sv]
// Controller state machine of the strip packer: loading, insertion sort and best-fit pass.
module bfd_ctrl
   import bfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       last_item,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [10:0] {
      IDLE     = 11'b00000000001,
      S_OUTER  = 11'b00000000010,
      S_LOADV  = 11'b00000000100,
      S_CHK    = 11'b00000001000,
      S_CMP    = 11'b00000010000,
      S_PLACE  = 11'b00000100000,
      P_OUTER  = 11'b00001000000,
      P_LOADW  = 11'b00010000000,
      P_SCAN   = 11'b00100000000,
      P_UPDATE = 11'b01000000000,
      DONE     = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_item) begin
                  cmd.sort_init = 1'b1;
                  state_in      = S_OUTER;
               end
            end
         end
         S_OUTER: begin
            if (status.i_done) begin
               cmd.pack_init = 1'b1;
               state_in      = P_OUTER;
            end else begin
               cmd.sort_readi = 1'b1;
               state_in       = S_LOADV;
            end
         end
         S_LOADV: begin
            cmd.sort_latch_v = 1'b1;
            state_in         = S_CHK;
         end
         S_CHK: begin
            if (status.j_zero) begin
               state_in = S_PLACE;
            end else begin
               cmd.sort_readj = 1'b1;
               state_in       = S_CMP;
            end
         end
         S_CMP: begin
            if (status.cmp_less) begin
               cmd.sort_shift = 1'b1;
               state_in       = S_CHK;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.sort_place = 1'b1;
            state_in       = S_OUTER;
         end
         P_OUTER: begin
            if (status.i_done) begin
               state_in = DONE;
            end else begin
               cmd.pack_readi = 1'b1;
               state_in       = P_LOADW;
            end
         end
         P_LOADW: begin
            cmd.pack_latch_w = 1'b1;
            state_in         = P_SCAN;
         end
         P_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = P_UPDATE;
            end
         end
         P_UPDATE: begin
            cmd.pack_update = 1'b1;
            state_in        = P_OUTER;
         end
         DONE: begin
            cmd.finish = 1'b1;
            state_in   = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != IDLE);

endmodule

[sv/bfd_dpath.sv]
// Datapath of the strip packer: item and row memories, counters and best-fit search.
module bfd_dpath
   import bfd_pkg::*;
#(
   parameter int MAX_ITEMS  = 1024,
   parameter int WIDTH_BITS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [WIDTH_BITS-1:0]  req_item_width,
   input  logic                   csr_we,
   input  logic [WIDTH_BITS-1:0]  csr_wdata,
   output logic                   rsp_valid,
   output logic [ROW_COUNT_W-1:0] rsp_row_count,
   output logic                   rsp_error_flag
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0]         count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [WIDTH_BITS-1:0] strip_ff;
   logic [CW-1:0]         i_ff, i_in;
   logic [CW-1:0]         j_ff, j_in;
   logic [WIDTH_BITS-1:0] v_ff, v_in;
   logic [WIDTH_BITS-1:0] w_ff, w_in;
   logic [CW-1:0]         r_ff, r_in;
   logic                  vld_ff, vld_in;
   logic [AW-1:0]         ridx_ff, ridx_in;
   logic                  found_ff, found_in;
   logic [WIDTH_BITS-1:0] best_ff, best_in;
   logic [AW-1:0]         pick_ff, pick_in;
   logic [CW-1:0]         rows_ff, rows_in;
   logic                  err_ff, err_in;

   logic                  item_we;
   logic [AW-1:0]         item_waddr, item_raddr;
   logic [WIDTH_BITS-1:0] item_wdata, item_rd;
   logic                  cap_we;
   logic [AW-1:0]         cap_waddr, cap_raddr;
   logic [WIDTH_BITS-1:0] cap_wdata, cap_rd;
   logic [CW-1:0]         jm1;
   logic                  r_live;

   assign jm1    = j_ff - 1'b1;
   assign r_live = (r_ff < rows_ff);

   bfd_ram #(.WIDTH(WIDTH_BITS), .DEPTH(MAX_ITEMS)) u_item_ram (
      .clock (clock),
      .we    (item_we),
      .waddr (item_waddr),
      .wdata (item_wdata),
      .raddr (item_raddr),
      .rdata (item_rd)
   );

   bfd_ram #(.WIDTH(WIDTH_BITS), .DEPTH(MAX_ITEMS)) u_cap_ram (
      .clock (clock),
      .we    (cap_we),
      .waddr (cap_waddr),
      .wdata (cap_wdata),
      .raddr (cap_raddr),
      .rdata (cap_rd)
   );

   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      v_in       = v_ff;
      w_in       = w_ff;
      r_in       = r_ff;
      vld_in     = vld_ff;
      ridx_in    = ridx_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      pick_in    = pick_ff;
      rows_in    = rows_ff;
      err_in     = err_ff;
      item_we    = 1'b0;
      item_waddr = j_ff[AW-1:0];
      item_wdata = v_ff;
      item_raddr = i_ff[AW-1:0];
      cap_we     = 1'b0;
      cap_waddr  = pick_ff;
      cap_wdata  = strip_ff;
      cap_raddr  = r_ff[AW-1:0];

      if (cmd.load) begin
         if (count_ff < CW'(MAX_ITEMS)) begin
            item_we    = 1'b1;
            item_waddr = count_ff[AW-1:0];
            item_wdata = req_item_width;
            count_in   = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.sort_init) begin
         i_in = '0;
      end
      if (cmd.sort_readi || cmd.pack_readi) begin
         item_raddr = i_ff[AW-1:0];
      end
      if (cmd.sort_latch_v) begin
         v_in = item_rd;
         j_in = i_ff;
      end
      if (cmd.sort_readj) begin
         item_raddr = jm1[AW-1:0];
      end
      if (cmd.sort_shift) begin
         item_we    = 1'b1;
         item_waddr = j_ff[AW-1:0];
         item_wdata = item_rd;
         j_in       = jm1;
      end
      if (cmd.sort_place) begin
         item_we    = 1'b1;
         item_waddr = j_ff[AW-1:0];
         item_wdata = v_ff;
         i_in       = i_ff + 1'b1;
      end
      if (cmd.pack_init) begin
         i_in    = '0;
         rows_in = '0;
         err_in  = 1'b0;
      end
      if (cmd.pack_latch_w) begin
         w_in     = item_rd;
         r_in     = '0;
         vld_in   = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         // Row reads are pipelined: one issued and one compared in each cycle.
         vld_in  = r_live;
         ridx_in = r_ff[AW-1:0];
         if (r_live) begin
            r_in = r_ff + 1'b1;
         end
         if (vld_ff && (cap_rd >= w_ff) && (!found_ff || (cap_rd < best_ff))) begin
            found_in = 1'b1;
            best_in  = cap_rd;
            pick_in  = ridx_ff;
         end
      end
      if (cmd.pack_update) begin
         cap_we = 1'b1;
         if (found_ff) begin
            cap_waddr = pick_ff;
            cap_wdata = best_ff - w_ff;
         end else begin
            // A new row is opened; an oversize item empties it and flags an error.
            cap_waddr = rows_ff[AW-1:0];
            if (strip_ff >= w_ff) begin
               cap_wdata = strip_ff - w_ff;
            end else begin
               cap_wdata = '0;
               err_in    = 1'b1;
            end
            rows_in = rows_ff + 1'b1;
         end
         i_in = i_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
         rows_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         strip_ff <= WIDTH_BITS'(16);
         rows_ff  <= '0;
         err_ff   <= 1'b0;
         vld_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         rows_ff  <= rows_in;
         err_ff   <= err_in;
         vld_ff   <= vld_in;
         found_ff <= found_in;
         if (csr_we) begin
            strip_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      r_ff    <= r_in;
      ridx_ff <= ridx_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
   end

   assign status.i_done    = (i_ff >= count_ff);
   assign status.j_zero    = (j_ff == '0);
   assign status.cmp_less  = (item_rd < v_ff);
   assign status.scan_done = !r_live && !vld_ff;

   assign rsp_valid      = cmd.finish;
   assign rsp_row_count  = ROW_COUNT_W'(rows_ff);
   assign rsp_error_flag = err_ff | ovf_ff;

   a_rows_bounded: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= count_ff)
      else $error("more rows open than items stored");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pack_update && found_ff |-> CW'(pick_ff) < rows_ff)
      else $error("chosen row is not an open row");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (count_ff == '0) && !ovf_ff)
      else $error("list state not cleared after result");

endmodule

[sv/best_fit_decreasing_strip_packer.sv]
// Top level of the best-fit decreasing strip packer.
//
// Each transaction on the request side (start high while busy is low) carries
// one item width; the item marked by req_last_item closes the list. Items are
// taken one per cycle while the list is loaded. At most MAX_ITEMS are stored;
// later items are dropped and the error flag is raised in the result.
// After the last item the block is busy: it sorts the stored widths in
// descending order by insertion sort in the item memory, then places each
// item in turn, scanning the open rows at one row per cycle through the row
// memory. One result then appears on rsp_valid for exactly one cycle with
// the row count and the error flag; the receiver cannot stall it, and busy
// falls in the following cycle. csr_wdata sets the strip width when csr_we
// is high and should be written only while busy is low.
// Reset returns the controller to idle, empties the list and sets the strip
// width to 16; memory contents need no clearing.
module best_fit_decreasing_strip_packer
   import bfd_pkg::*;
#(
   parameter int MAX_ITEMS  = 1024,
   parameter int WIDTH_BITS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [WIDTH_BITS-1:0]  req_item_width,
   input  logic                   req_last_item,
   input  logic                   csr_we,
   input  logic [WIDTH_BITS-1:0]  csr_wdata,
   output logic                   rsp_valid,
   output logic [ROW_COUNT_W-1:0] rsp_row_count,
   output logic                   rsp_error_flag
);

   cmd_type    cmd;
   status_type status;

   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_item (req_last_item),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   bfd_dpath #(.MAX_ITEMS(MAX_ITEMS), .WIDTH_BITS(WIDTH_BITS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_item_width (req_item_width),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_row_count  (rsp_row_count),
      .rsp_error_flag (rsp_error_flag)
   );

endmodule

[tb/best_fit_decreasing_strip_packer_tb.sv]
// Testbench of the best-fit decreasing strip packer: directed and random item lists.
module best_fit_decreasing_strip_packer_tb
   import bfd_pkg::*;
();

   localparam int MAX_ITEMS  = 1024;
   localparam int WIDTH_BITS = 30;
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

   typedef struct {
      logic [ROW_COUNT_W-1:0] row_count;
      logic                   error_flag;
   } packing_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [WIDTH_BITS-1:0]  req_item_width;
   logic                   req_last_item;
   logic                   csr_we;
   logic [WIDTH_BITS-1:0]  csr_wdata;
   logic                   rsp_valid;
   logic [ROW_COUNT_W-1:0] rsp_row_count;
   logic                   rsp_error_flag;

   logic [WIDTH_BITS-1:0] strip_width_model;
   logic [WIDTH_BITS-1:0] pending_widths[$];
   logic                  list_overflowed;
   packing_type           expected_packings[$];
   int                    mismatch_count;
   int                    sender_idle_pct;

   best_fit_decreasing_strip_packer #(
      .MAX_ITEMS (MAX_ITEMS),
      .WIDTH_BITS(WIDTH_BITS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item_width(req_item_width),
      .req_last_item (req_last_item),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_row_count (rsp_row_count),
      .rsp_error_flag(rsp_error_flag)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Best-fit decreasing over the buffered list, as the block should compute it.
   function automatic packing_type pack_rows();
      packing_type         res;
      longint unsigned     caps[$];
      logic [WIDTH_BITS-1:0] sorted[$];
      longint unsigned     w;
      int                  pick;
      bit                  err;
      sorted = pending_widths;
      sorted.rsort();
      err = list_overflowed;
      foreach (sorted[i]) begin
         w = longint'(sorted[i]);
         pick = -1;
         foreach (caps[r])
            if (caps[r] >= w && (pick < 0 || caps[r] < caps[pick]))
               pick = r;
         if (pick < 0) begin
            if (caps.size() >= MAX_ITEMS) begin
               err = 1'b1;
               continue;
            end
            caps = {caps, longint'(strip_width_model)};
            pick = caps.size() - 1;
         end
         if (caps[pick] >= w)
            caps[pick] -= w;
         else begin
            caps[pick] = 0;
            err = 1'b1;
         end
      end
      res.row_count  = ROW_COUNT_W'(caps.size());
      res.error_flag = err;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      packing_type exp_p;
      if (!reset && rsp_valid) begin
         if (expected_packings.size() == 0)
            report_mismatch("result with no transaction outstanding");
         else begin
            exp_p = expected_packings.pop_front();
            if (rsp_row_count !== exp_p.row_count)
               report_mismatch($sformatf("row_count %0d, expected %0d",
                                         rsp_row_count, exp_p.row_count));
            if (rsp_error_flag !== exp_p.error_flag)
               report_mismatch($sformatf("error_flag %0b, expected %0b",
                                         rsp_error_flag, exp_p.error_flag));
         end
      end
   end

   // Start stays high between back-to-back transactions; it drops only for a gap.
   task automatic send_item(input logic [WIDTH_BITS-1:0] w, input logic last);
      start          <= 1'b1;
      req_item_width <= w;
      req_last_item  <= last;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (pending_widths.size() < MAX_ITEMS)
         pending_widths = {pending_widths, w};
      else
         list_overflowed = 1'b1;
      if (last) begin
         expected_packings = {expected_packings, pack_rows()};
         pending_widths.delete();
         list_overflowed = 1'b0;
      end
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1))
            @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_packings.size() != 0 || busy)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   task automatic write_strip_width(input logic [WIDTH_BITS-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      strip_width_model = value;
      csr_we <= 1'b0;
   endtask

   function automatic logic [WIDTH_BITS-1:0] random_width();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 60)
         return WIDTH_BITS'($urandom_range(strip_width_model > 1 ? strip_width_model : 1, 0));
      else if (sel < 70)
         return strip_width_model;
      else if (sel < 78)
         return strip_width_model + 1'b1;
      else if (sel < 84)
         return '0;
      else if (sel < 90)
         return WIDTH_MAX;
      return WIDTH_BITS'($urandom());
   endfunction

   task automatic send_list(input int n);
      for (int i = 0; i < n; i++)
         send_item(random_width(), i == n - 1);
   endtask

   task automatic test_directed();
      send_item(30'd16, 1'b1);
      send_item(30'd17, 1'b1);
      send_item('0, 1'b1);
      send_item(WIDTH_MAX, 1'b1);
      send_item(30'd3, 1'b0);
      send_item(30'd9, 1'b0);
      send_item('0, 1'b0);
      send_item(30'd7, 1'b0);
      send_item(30'd13, 1'b0);
      send_item(30'd4, 1'b1);
      write_strip_width(WIDTH_MAX);
      send_item(WIDTH_MAX, 1'b0);
      send_item(30'h2AAAAAAA, 1'b0);
      send_item(30'h15555555, 1'b1);
      write_strip_width(30'd1);
      send_item(30'd1, 1'b0);
      send_item(30'd1, 1'b0);
      send_item(30'd2, 1'b1);
      // A zero strip makes every nonzero item oversize.
      write_strip_width('0);
      send_item('0, 1'b0);
      send_item(30'd5, 1'b1);
   endtask

   task automatic test_random(input int idle_pct, input int items);
      int sent;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < items) begin
         int n;
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
               0: write_strip_width(WIDTH_BITS'($urandom_range(40, 1)));
               1: write_strip_width(WIDTH_MAX);
               2: write_strip_width(30'd1);
               default: write_strip_width(WIDTH_BITS'($urandom()));
            endcase
         end
         n = $urandom_range(9, 1);
         send_list(n);
         sent += n;
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_item_width  = '0;
      req_last_item   = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      strip_width_model = 30'd16;
      list_overflowed = 1'b0;
      mismatch_count  = 0;
      sender_idle_pct = 7;
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(7, 187);
      test_random(79, 187);
      test_random(0, 187);
      wait_idle();
      repeat (20)
         @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
